>>> design/rqcp_pkg.sv
// ----------------------------------------------------------------------------
// RGB to quantized CMYK packer: shared package
// Types, register indexes, reset values and the quantizer shared by the
// divider cells and the top level.
// ----------------------------------------------------------------------------
package rqcp_pkg;

    // Pixel and component width.
    localparam int unsigned PIX_W = 8;

    // Number of color lanes divided in parallel (cyan, magenta, yellow).
    localparam int unsigned LANES = 3;

    // One divider cell resolves one quotient bit.
    localparam int unsigned NUM_CELLS = PIX_W;

    // Full-scale component value.
    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

    // Configuration register indexes.
    localparam int unsigned      REG_IDX_W          = 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_MID  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_HIGH = 2'd2;

    // Threshold reset values.
    localparam logic [PIX_W-1:0] RST_THRESHOLD_LOW  = 8'd0;
    localparam logic [PIX_W-1:0] RST_THRESHOLD_MID  = 8'd100;
    localparam logic [PIX_W-1:0] RST_THRESHOLD_HIGH = 8'd180;

    // Two-bit quantizer levels.
    localparam logic [1:0] QUANT_LEVEL0 = 2'd0;
    localparam logic [1:0] QUANT_LEVEL1 = 2'd1;
    localparam logic [1:0] QUANT_LEVEL2 = 2'd2;
    localparam logic [1:0] QUANT_LEVEL3 = 2'd3;

    // Per-lane divider state: partial remainder and the shift word that
    // holds the unused numerator bits on the left and quotient bits on the
    // right.
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [PIX_W-1:0] work;
    } lane_t;

    // Everything one item carries from cell to cell.
    typedef struct packed {
        logic [PIX_W-1:0]      divisor;
        logic [PIX_W-1:0]      black;
        lane_t [LANES-1:0]     lanes;
    } stage_t;

    // Thresholds are tested in fixed order; the first that holds wins.
    function automatic logic [1:0] quantize(
        input logic [PIX_W-1:0] value,
        input logic [PIX_W-1:0] t_low,
        input logic [PIX_W-1:0] t_mid,
        input logic [PIX_W-1:0] t_high
    );
        logic [1:0] level;
        if (value <= t_low)
        begin
            level = QUANT_LEVEL0;
        end
        else if (value <= t_mid)
        begin
            level = QUANT_LEVEL1;
        end
        else if (value <= t_high)
        begin
            level = QUANT_LEVEL2;
        end
        else
        begin
            level = QUANT_LEVEL3;
        end
        return level;
    endfunction

endpackage

>>> design/rqcp_div_cell.sv
// ----------------------------------------------------------------------------
// RGB to quantized CMYK packer: divider cell
// One restoring-division step for each color lane. Each cell resolves one
// quotient bit and hands the item to the next cell in the row.
// ----------------------------------------------------------------------------
module rqcp_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  rqcp_pkg::stage_t  in_stage,
    output logic              out_valid,
    output rqcp_pkg::stage_t  out_stage
);

    logic             valid_reg;
    rqcp_pkg::stage_t stage_reg;
    rqcp_pkg::stage_t stage_next;

    // Divisor and key value pass through unchanged.
    assign stage_next.divisor = in_stage.divisor;
    assign stage_next.black   = in_stage.black;

    // One trial subtraction per lane.
    genvar gl;
    generate
        for (gl = 0; gl < rqcp_pkg::LANES; gl++)
        begin : g_lane
            logic [rqcp_pkg::PIX_W:0] trial;
            logic [rqcp_pkg::PIX_W:0] diff;
            logic                     fits;

            assign trial = {in_stage.lanes[gl].rem,
                            in_stage.lanes[gl].work[rqcp_pkg::PIX_W-1]};
            assign diff  = trial - {1'b0, in_stage.divisor};
            assign fits  = (trial >= {1'b0, in_stage.divisor});

            assign stage_next.lanes[gl].rem  = fits ? diff[rqcp_pkg::PIX_W-1:0]
                                                    : trial[rqcp_pkg::PIX_W-1:0];
            assign stage_next.lanes[gl].work = {in_stage.lanes[gl].work[rqcp_pkg::PIX_W-2:0],
                                                fits};
        end
    endgenerate

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Item payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

>>> design/rgb_to_quantized_cmyk_packer.sv
// ----------------------------------------------------------------------------
// RGB to quantized CMYK packer
// Converts one RGB pixel per clock, unless the output stalls, to CMYK and packs two-bit codes.
//
//   Channel  Direction  Handshake            Payload
//   in       to block   in_valid / in_stall  red, green, blue
//   out      from block out_valid / out_stall packed_code, cyan, magenta,
//                                            yellow, black
//   cfg      to block   wr_en                wr_index, wr_data
//
// One item is accepted per clock unless the output stalls. Each item passes
// through one front stage, eight divider cells (one quotient bit each) and
// the output register.
// Reset clears the valid flags and loads the threshold reset values.
// A stalled output freezes the whole row, and the input stalls with it.
// ----------------------------------------------------------------------------
module rgb_to_quantized_cmyk_packer (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] packed_code,
    output logic [7:0] cyan,
    output logic [7:0] magenta,
    output logic [7:0] yellow,
    output logic [7:0] black,

    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [7:0] wr_data
);

    localparam int unsigned W = rqcp_pkg::PIX_W;

    logic [W-1:0] threshold_low_reg;
    logic [W-1:0] threshold_mid_reg;
    logic [W-1:0] threshold_high_reg;

    logic         advance;

    logic             cell_valid [0:rqcp_pkg::NUM_CELLS];
    rqcp_pkg::stage_t cell_stage [0:rqcp_pkg::NUM_CELLS];

    logic         front_valid_reg;
    rqcp_pkg::stage_t front_reg;
    rqcp_pkg::stage_t front_next;

    logic [W-1:0] max_rg;
    logic [W-1:0] max_rgb;
    logic [W-1:0] chan [rqcp_pkg::LANES];

    logic         out_valid_reg;
    logic [W-1:0] packed_reg;
    logic [W-1:0] cyan_reg;
    logic [W-1:0] magenta_reg;
    logic [W-1:0] yellow_reg;
    logic [W-1:0] black_reg;
    logic [W-1:0] packed_next;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_low_reg  <= rqcp_pkg::RST_THRESHOLD_LOW;
            threshold_mid_reg  <= rqcp_pkg::RST_THRESHOLD_MID;
            threshold_high_reg <= rqcp_pkg::RST_THRESHOLD_HIGH;
        end
        else if (wr_en)
        begin
            case (wr_index)
                rqcp_pkg::REG_THRESHOLD_LOW:  threshold_low_reg  <= wr_data;
                rqcp_pkg::REG_THRESHOLD_MID:  threshold_mid_reg  <= wr_data;
                rqcp_pkg::REG_THRESHOLD_HIGH: threshold_high_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // The whole row moves unless a finished item is held at the output.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // Front stage: largest channel, key value and the scaled numerators.
    assign max_rg  = (green > red) ? green : red;
    assign max_rgb = (blue > max_rg) ? blue : max_rg;
    assign chan[0] = red;
    assign chan[1] = green;
    assign chan[2] = blue;

    // A black pixel divides zero by full scale, which gives zero.
    assign front_next.divisor = (max_rgb == '0) ? rqcp_pkg::FULL_SCALE : max_rgb;
    assign front_next.black   = rqcp_pkg::FULL_SCALE - max_rgb;

    genvar gl;
    generate
        for (gl = 0; gl < rqcp_pkg::LANES; gl++)
        begin : g_front
            logic [W-1:0]   delta;
            logic [2*W-1:0] numer;

            // delta * 255 as delta * 256 - delta.
            assign delta = max_rgb - chan[gl];
            assign numer = {delta, {W{1'b0}}} - {{W{1'b0}}, delta};
            assign front_next.lanes[gl].rem  = numer[2*W-1:W];
            assign front_next.lanes[gl].work = numer[W-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg <= front_next;
        end
    end

    assign cell_valid[0] = front_valid_reg;
    assign cell_stage[0] = front_reg;

    // Row of divider cells, one quotient bit each.
    genvar gc;
    generate
        for (gc = 0; gc < rqcp_pkg::NUM_CELLS; gc++)
        begin : g_cell
            rqcp_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (cell_valid[gc]),
                .in_stage  (cell_stage[gc]),
                .out_valid (cell_valid[gc+1]),
                .out_stage (cell_stage[gc+1])
            );
        end
    endgenerate

    // Quantize the four components and pack them, cyan in the top bits.
    assign packed_next = {
        rqcp_pkg::quantize(cell_stage[rqcp_pkg::NUM_CELLS].lanes[0].work,
                           threshold_low_reg, threshold_mid_reg, threshold_high_reg),
        rqcp_pkg::quantize(cell_stage[rqcp_pkg::NUM_CELLS].lanes[1].work,
                           threshold_low_reg, threshold_mid_reg, threshold_high_reg),
        rqcp_pkg::quantize(cell_stage[rqcp_pkg::NUM_CELLS].lanes[2].work,
                           threshold_low_reg, threshold_mid_reg, threshold_high_reg),
        rqcp_pkg::quantize(cell_stage[rqcp_pkg::NUM_CELLS].black,
                           threshold_low_reg, threshold_mid_reg, threshold_high_reg)
    };

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cell_valid[rqcp_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            packed_reg  <= packed_next;
            cyan_reg    <= cell_stage[rqcp_pkg::NUM_CELLS].lanes[0].work;
            magenta_reg <= cell_stage[rqcp_pkg::NUM_CELLS].lanes[1].work;
            yellow_reg  <= cell_stage[rqcp_pkg::NUM_CELLS].lanes[2].work;
            black_reg   <= cell_stage[rqcp_pkg::NUM_CELLS].black;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packed_code = packed_reg;
    assign cyan        = cyan_reg;
    assign magenta     = magenta_reg;
    assign yellow      = yellow_reg;
    assign black       = black_reg;

`ifndef SYNTHESIS
    // The input never stalls while the output register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
    else $error("input stalled with an empty output register");

    // The remainder at the end of the row is always below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[rqcp_pkg::NUM_CELLS] |->
            (cell_stage[rqcp_pkg::NUM_CELLS].lanes[0].rem
                < cell_stage[rqcp_pkg::NUM_CELLS].divisor) &&
            (cell_stage[rqcp_pkg::NUM_CELLS].lanes[1].rem
                < cell_stage[rqcp_pkg::NUM_CELLS].divisor) &&
            (cell_stage[rqcp_pkg::NUM_CELLS].lanes[2].rem
                < cell_stage[rqcp_pkg::NUM_CELLS].divisor))
    else $error("divider remainder not below divisor");

    // The largest channel always gives a zero color component.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cyan_reg == '0) || (magenta_reg == '0) || (yellow_reg == '0))
    else $error("no color component is zero");

    // A black pixel gives no color.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (black_reg == rqcp_pkg::FULL_SCALE)) |->
            (cyan_reg == '0) && (magenta_reg == '0) && (yellow_reg == '0))
    else $error("black pixel produced color");

    // An item accepted with a free row is in the front stage register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> front_valid_reg)
    else $error("accepted item lost at the front stage");
`endif

endmodule

>>> tb/sv/rgb_to_quantized_cmyk_packer_tb.sv
// ----------------------------------------------------------------------------
// RGB to quantized CMYK packer: self-checking testbench
// Streams pixels through the block under several threshold settings and
// changing back pressure. A scoreboard predicts the raw CMYK components and
// the packed two-bit codes of each accepted pixel, then compares them in
// order with the items that leave the block.
// ----------------------------------------------------------------------------
module rgb_to_quantized_cmyk_packer_tb;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    // Idle wait after the last result has left the block.
    localparam int unsigned PIPE_SETTLE     = 14;
    localparam int unsigned ITEMS_PER_PHASE = 205;
    localparam int unsigned NUM_PHASES      = 6;
    localparam logic [rqcp_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // One result item of the block.
    typedef struct packed {
        logic [rqcp_pkg::PIX_W-1:0] code;
        logic [rqcp_pkg::PIX_W-1:0] cyan;
        logic [rqcp_pkg::PIX_W-1:0] magenta;
        logic [rqcp_pkg::PIX_W-1:0] yellow;
        logic [rqcp_pkg::PIX_W-1:0] black;
    } cmyk_t;

    // Predicts the CMYK item of each accepted pixel and checks the results.
    class cmyk_scoreboard;
        logic [rqcp_pkg::PIX_W-1:0] t_low;
        logic [rqcp_pkg::PIX_W-1:0] t_mid;
        logic [rqcp_pkg::PIX_W-1:0] t_high;
        cmyk_t                      pending[$];
        int unsigned                errors;

        function new();
            t_low  = rqcp_pkg::RST_THRESHOLD_LOW;
            t_mid  = rqcp_pkg::RST_THRESHOLD_MID;
            t_high = rqcp_pkg::RST_THRESHOLD_HIGH;
            errors = 0;
        endfunction

        // Mirror a register write; an unused index leaves everything alone.
        function void set_threshold(logic [rqcp_pkg::REG_IDX_W-1:0] idx,
                                    logic [rqcp_pkg::PIX_W-1:0] value);
            case (idx)
                rqcp_pkg::REG_THRESHOLD_LOW:  t_low  = value;
                rqcp_pkg::REG_THRESHOLD_MID:  t_mid  = value;
                rqcp_pkg::REG_THRESHOLD_HIGH: t_high = value;
                default: ;
            endcase
        endfunction

        // The first threshold that holds, in the order low, mid, high, decides.
        function logic [1:0] level_of(logic [rqcp_pkg::PIX_W-1:0] v);
            if (v <= t_low)
                return rqcp_pkg::QUANT_LEVEL0;
            if (v <= t_mid)
                return rqcp_pkg::QUANT_LEVEL1;
            if (v <= t_high)
                return rqcp_pkg::QUANT_LEVEL2;
            return rqcp_pkg::QUANT_LEVEL3;
        endfunction

        // Exact integer ink amount of one channel; a black pixel has no ink.
        function logic [rqcp_pkg::PIX_W-1:0] ink(logic [rqcp_pkg::PIX_W-1:0] peak,
                                                 logic [rqcp_pkg::PIX_W-1:0] chan);
            int unsigned scaled;
            if (peak == '0)
                return '0;
            scaled = ((int'(peak) - int'(chan)) * int'(rqcp_pkg::FULL_SCALE))
                     / int'(peak);
            return scaled[rqcp_pkg::PIX_W-1:0];
        endfunction

        function void note_pixel(logic [rqcp_pkg::PIX_W-1:0] r,
                                 logic [rqcp_pkg::PIX_W-1:0] g,
                                 logic [rqcp_pkg::PIX_W-1:0] b);
            cmyk_t                      want;
            logic [rqcp_pkg::PIX_W-1:0] peak;
            peak = r;
            if (g > peak)
                peak = g;
            if (b > peak)
                peak = b;
            want.black   = rqcp_pkg::FULL_SCALE - peak;
            want.cyan    = ink(peak, r);
            want.magenta = ink(peak, g);
            want.yellow  = ink(peak, b);
            want.code    = {level_of(want.cyan), level_of(want.magenta),
                            level_of(want.yellow), level_of(want.black)};
            pending.push_back(want);
        endfunction

        function void report(string field, logic [rqcp_pkg::PIX_W-1:0] want,
                             logic [rqcp_pkg::PIX_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(cmyk_t got);
            cmyk_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with no pixel pending, got code %0d", $time, got.code);
                return;
            end
            want = pending.pop_front();
            if (got.code !== want.code)
                report("packed_code", want.code, got.code);
            if (got.cyan !== want.cyan)
                report("cyan", want.cyan, got.cyan);
            if (got.magenta !== want.magenta)
                report("magenta", want.magenta, got.magenta);
            if (got.yellow !== want.yellow)
                report("yellow", want.yellow, got.yellow);
            if (got.black !== want.black)
                report("black", want.black, got.black);
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [rqcp_pkg::PIX_W-1:0]     red;
    logic [rqcp_pkg::PIX_W-1:0]     green;
    logic [rqcp_pkg::PIX_W-1:0]     blue;
    logic                           out_valid;
    logic                           out_stall;
    logic [rqcp_pkg::PIX_W-1:0]     packed_code;
    logic [rqcp_pkg::PIX_W-1:0]     cyan;
    logic [rqcp_pkg::PIX_W-1:0]     magenta;
    logic [rqcp_pkg::PIX_W-1:0]     yellow;
    logic [rqcp_pkg::PIX_W-1:0]     black;
    logic                           wr_en;
    logic [rqcp_pkg::REG_IDX_W-1:0] wr_index;
    logic [rqcp_pkg::PIX_W-1:0]     wr_data;

    cmyk_scoreboard sb;
    int unsigned    in_idle_pct;
    int unsigned    out_idle_pct;
    int unsigned    cycle_count;
    cmyk_t          seen;

    rgb_to_quantized_cmyk_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_code (packed_code),
        .cyan        (cyan),
        .magenta     (magenta),
        .yellow      (yellow),
        .black       (black),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data)
    );

    // Clock with a period of 20 time units.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Random back pressure from the receiving side.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // Watch both channels at the clock edge that moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_pixel(red, green, blue);
            if (out_valid && !out_stall)
            begin
                seen = {packed_code, cyan, magenta, yellow, black};
                sb.check_result(seen);
            end
        end
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rgb_to_quantized_cmyk_packer_tb: done, errors");
            $finish;
        end
    end

    // Offer one pixel, with random idle cycles first, and hold it until taken.
    task automatic send_pixel(input logic [rqcp_pkg::PIX_W-1:0] r,
                              input logic [rqcp_pkg::PIX_W-1:0] g,
                              input logic [rqcp_pkg::PIX_W-1:0] b);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Pixels of several shapes: plain random, gray, tiny peaks, saturated or
    // empty channels, and channels just under the peak.
    task automatic random_pixel();
        logic [rqcp_pkg::PIX_W-1:0] r;
        logic [rqcp_pkg::PIX_W-1:0] g;
        logic [rqcp_pkg::PIX_W-1:0] b;
        logic [rqcp_pkg::PIX_W-1:0] peak;
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            1:
            begin
                g = r;
                b = r;
            end
            2:
            begin
                r = 8'($urandom_range(0, 3));
                g = 8'($urandom_range(0, 3));
                b = 8'($urandom_range(0, 3));
            end
            3:
            begin
                case ($urandom_range(0, 2))
                    0: r = rqcp_pkg::FULL_SCALE;
                    1: g = rqcp_pkg::FULL_SCALE;
                    default: b = rqcp_pkg::FULL_SCALE;
                endcase
            end
            4:
            begin
                case ($urandom_range(0, 2))
                    0: r = '0;
                    1: g = '0;
                    default: b = '0;
                endcase
            end
            5:
            begin
                peak = r;
                g = (peak > 3) ? peak - 8'($urandom_range(0, 3)) : peak;
                b = (peak > 3) ? peak - 8'($urandom_range(0, 3)) : '0;
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    // Stop offering pixels and wait until the pipeline has emptied.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    // Write all three thresholds plus one write to the unused index.
    task automatic set_thresholds(input logic [rqcp_pkg::PIX_W-1:0] lo,
                                  input logic [rqcp_pkg::PIX_W-1:0] mid,
                                  input logic [rqcp_pkg::PIX_W-1:0] hi);
        logic [rqcp_pkg::REG_IDX_W-1:0] idx_list [4];
        logic [rqcp_pkg::PIX_W-1:0]     val_list [4];
        idx_list = '{REG_UNUSED, rqcp_pkg::REG_THRESHOLD_LOW, rqcp_pkg::REG_THRESHOLD_MID,
                     rqcp_pkg::REG_THRESHOLD_HIGH};
        val_list = '{8'($urandom_range(0, 255)), lo, mid, hi};
        for (int i = 0; i < 4; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= idx_list[i];
            wr_data  <= val_list[i];
            sb.set_threshold(idx_list[i], val_list[i]);
            @(negedge clk);
        end
        wr_en <= 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        logic [23:0] presets [20];
        presets = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                    24'h010000, 24'h010101, 24'h000001, 24'h020100, 24'hFFFE00,
                    24'h804020, 24'h0001FF, 24'hC8C800, 24'h11FFFE, 24'h01FF80,
                    24'hFF8001, 24'hFEFEFF, 24'h646464, 24'h7F8081, 24'hAA55FF};
        sb           = new();
        cycle_count  = 0;
        in_idle_pct  = 18;
        out_idle_pct = 83;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        red          = '0;
        green        = '0;
        blue         = '0;
        out_stall    = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pixels under the reset thresholds: black, white, primaries,
        // tiny peaks and channels next to the peak.
        foreach (presets[i])
            send_pixel(presets[i][23:16], presets[i][15:8], presets[i][7:0]);

        // Random phases, each under its own threshold setting.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 2)
            begin
                in_idle_pct  = 83;
                out_idle_pct = 18;
            end
            else if (phase == 4)
            begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (phase != 0)
            begin
                wait_idle();
                case (phase)
                    1: set_thresholds(8'd0, 8'd0, 8'd0);
                    2: set_thresholds(8'd255, 8'd255, 8'd255);
                    3: set_thresholds(8'd64, 8'd128, 8'd192);
                    // Thresholds out of order.
                    4: set_thresholds(8'd200, 8'd50, 8'd100);
                    default: set_thresholds(8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)),
                                            8'($urandom_range(0, 255)));
                endcase
            end
            repeat (ITEMS_PER_PHASE) random_pixel();
        end

        wait_idle();
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("rgb_to_quantized_cmyk_packer_tb: done, clean");
        end
        else
        begin
            $display("rgb_to_quantized_cmyk_packer_tb: done, errors");
        end
        $finish;
    end

endmodule
